/* design/assert_macros.svh */
// Assertion helpers shared by the decoder modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset
`define HUFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that a condition never holds outside reset
`define HUFD_NEVER(lbl, clk, rstn, cond, msg) \
  `HUFD_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define HUFD_ASSERT(lbl, clk, rstn, prop, msg)
`define HUFD_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* design/hufd_pkg.sv */
`timescale 1ns / 1ps

package hufd_pkg;

  // Field widths
  localparam int unsigned NODE_W  = 8;
  localparam int unsigned LINK_W  = 9;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned LEN_W   = 24;
  localparam int unsigned BIT_W   = $clog2(CODE_W);
  localparam int unsigned ENTRY_W = 2 * LINK_W;

  // Default tree geometry
  localparam int unsigned DEF_NODE_COUNT = 255;
  localparam int unsigned DEF_HEAD_NODE  = 254;

  // Chunk length after reset
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

  // Input commands
  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             chunk_end;
    logic             bad_link;
  } res_t;

endpackage

/* design/hufd_ram.sv */
`timescale 1ns / 1ps

module hufd_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 255,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/hufd_walker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hufd_walker import hufd_pkg::*; #(
  parameter int unsigned NODE_COUNT = DEF_NODE_COUNT,
  parameter int unsigned HEAD_NODE  = DEF_HEAD_NODE,
  parameter int unsigned AW         = $clog2(DEF_NODE_COUNT)
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [LEN_W-1:0]   cfg_wr_data,
  // input transactions
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [NODE_W-1:0]  in_node_index,
  input  logic [LINK_W-1:0]  in_link_zero,
  input  logic [LINK_W-1:0]  in_link_one,
  input  logic [CODE_W-1:0]  in_code_byte,
  // node table
  output logic               tbl_wr_en,
  output logic [AW-1:0]      tbl_wr_addr,
  output logic [ENTRY_W-1:0] tbl_wr_data,
  output logic [AW-1:0]      tbl_rd_addr,
  input  logic [ENTRY_W-1:0] tbl_rd_data,
  // result hand-off to the output stage
  input  logic               out_free,
  output logic               push,
  output res_t               push_res
);

  localparam logic [NODE_W-1:0] NODE_LIM  = NODE_W'(NODE_COUNT);
  localparam logic [NODE_W-1:0] HEAD      = NODE_W'(HEAD_NODE);
  localparam logic [BIT_W-1:0]  LAST_BIT  = BIT_W'(CODE_W - 1);
  localparam logic [LEN_W:0]    FULL_LEN  = {1'b1, {LEN_W{1'b0}}};

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t             state_r, state_nxt;
  logic [BIT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [NODE_W-1:0]  cur_node_r, cur_node_nxt;
  logic               node_ok_r, node_ok_nxt;
  logic [LEN_W-1:0]   done_r, done_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               pend_v_r, pend_v_nxt;
  res_t               pend_r, pend_nxt;

  logic               accept;
  logic               walk;
  logic [LINK_W-1:0]  link;
  logic               is_sym;
  logic [NODE_W-1:0]  link_node;
  logic               bad;
  logic               new_res;
  logic [LEN_W:0]     done_inc;
  logic [LEN_W:0]     limit;
  logic               hit_end;
  logic               item_done;
  logic               stall;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign walk     = (state_r == S_WALK);

  // Load transactions write one node; nodes outside the table are dropped
  assign tbl_wr_en   = accept && (in_command == CMD_LOAD) && (in_node_index < NODE_LIM);
  assign tbl_wr_addr = in_node_index[AW-1:0];
  assign tbl_wr_data = {in_link_one, in_link_zero};

  // Read the node that will be examined next cycle
  assign tbl_rd_addr = cur_node_nxt[AW-1:0];
  assign node_ok_nxt = (cur_node_nxt < NODE_LIM);

  // Pick the link for the current code bit; a node outside the table has zero links
  always_comb begin
    link = '0;
    if (node_ok_r) begin
      link = code_r[bit_cnt_r] ? tbl_rd_data[ENTRY_W-1:LINK_W] : tbl_rd_data[LINK_W-1:0];
    end
  end

  assign is_sym    = !link[LINK_W-1];
  assign link_node = link[NODE_W-1:0];
  assign bad       = link[LINK_W-1] && (link_node >= NODE_LIM);
  assign new_res   = walk && (is_sym || bad);

  // Chunk length compare; a zero length stands for the full counter range
  assign done_inc = (LEN_W + 1)'(done_r) + 1'b1;
  assign limit    = (len_r == '0) ? FULL_LEN : {1'b0, len_r};
  assign hit_end  = (done_inc >= limit);

  assign item_done = (bit_cnt_r == LAST_BIT) || (is_sym && hit_end) || bad;
  assign stall     = new_res && pend_v_r && !out_free;

  // The pending result leaves once its successor exists or its transaction ends
  assign push     = pend_v_r && out_free && (pend_r.last || new_res);
  assign push_res = pend_r;

  // Sequencer: one table read per code bit
  always_comb begin
    state_nxt    = state_r;
    bit_cnt_nxt  = bit_cnt_r;
    code_nxt     = code_r;
    cur_node_nxt = cur_node_r;
    done_nxt     = done_r;
    len_nxt      = len_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;

    if (cfg_wr_en) begin
      len_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (accept && (in_command == CMD_DECODE)) begin
          code_nxt    = in_code_byte;
          bit_cnt_nxt = '0;
          state_nxt   = S_WALK;
        end
      end
      S_WALK: begin
        if (!stall) begin
          // advance the tree walk
          if (is_sym || bad) begin
            cur_node_nxt = HEAD;
          end else begin
            cur_node_nxt = link_node;
          end
          if (bad) begin
            done_nxt = '0;
          end else if (is_sym) begin
            done_nxt = hit_end ? '0 : done_inc[LEN_W-1:0];
          end
          if (item_done) begin
            bit_cnt_nxt = '0;
            state_nxt   = S_IDLE;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Hold the newest result until the next one or the end of its transaction
    if (new_res && !stall) begin
      pend_v_nxt          = 1'b1;
      pend_nxt.symbol     = bad ? '0 : link[SYM_W-1:0];
      pend_nxt.chunk_end  = is_sym && hit_end;
      pend_nxt.bad_link   = bad;
      pend_nxt.last       = item_done;
    end else if (push) begin
      pend_v_nxt    = 1'b0;
      pend_nxt.last = 1'b0;
    end else if (walk && item_done && !stall && pend_v_r) begin
      pend_nxt.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      bit_cnt_r  <= '0;
      cur_node_r <= HEAD;
      node_ok_r  <= 1'b0;
      done_r     <= '0;
      len_r      <= LEN_RESET;
      pend_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      cur_node_r <= cur_node_nxt;
      node_ok_r  <= node_ok_nxt;
      done_r     <= done_nxt;
      len_r      <= len_nxt;
      pend_v_r   <= pend_v_nxt;
    end
    code_r <= code_nxt;
    pend_r <= pend_nxt;
  end

  `HUFD_ASSERT(a_idle_bit_zero, clk, rst_n, (state_r == S_IDLE) |-> (bit_cnt_r == '0), "bit counter not cleared in idle")
  `HUFD_NEVER(a_push_when_full, clk, rst_n, push && !out_free, "result pushed into a full output stage")
  `HUFD_ASSERT(a_decode_walks, clk, rst_n, (accept && (in_command == CMD_DECODE)) |=> (state_r == S_WALK), "decode transaction did not start a walk")
  `HUFD_ASSERT(a_idle_pend_final, clk, rst_n, (state_r == S_IDLE && pend_v_r) |-> pend_r.last, "pending result left unterminated after its transaction")

endmodule

/* design/huffman_tree_decoder_top.sv */
`timescale 1ns / 1ps
// Load transaction: written into the node table at acceptance, back to back.
// Decode transaction: one dependent table read per code bit, up to all 8 bits of the code byte
//   (fewer on a chunk end or bad link, longer while the output is full), then back to idle.
// A new transaction is accepted only in idle; each result is held in a pending register until
//   its successor exists or its end-of-transaction flag is known, then goes to the output register.
// Reset (rst_n, synchronous, active low): head node, count cleared, length 1, table kept.
`include "assert_macros.svh"

module huffman_tree_decoder_top import hufd_pkg::*; #(
  parameter int unsigned NODE_COUNT = DEF_NODE_COUNT,
  parameter int unsigned HEAD_NODE  = DEF_HEAD_NODE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [NODE_W-1:0] in_node_index,
  input  logic [LINK_W-1:0] in_link_zero,
  input  logic [LINK_W-1:0] in_link_one,
  input  logic [CODE_W-1:0] in_code_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SYM_W-1:0]  out_symbol,
  output logic              out_last_of_item,
  output logic              out_chunk_end,
  output logic              out_bad_link
);

  localparam int unsigned AW = $clog2(NODE_COUNT);

  logic               tbl_wr_en;
  logic [AW-1:0]      tbl_wr_addr;
  logic [ENTRY_W-1:0] tbl_wr_data;
  logic [AW-1:0]      tbl_rd_addr;
  logic [ENTRY_W-1:0] tbl_rd_data;
  logic               out_free;
  logic               push;
  res_t               push_res;
  logic               out_valid_r;
  res_t               out_res_r;

  hufd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT),
    .AW    (AW)
  ) u_node_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  hufd_walker #(
    .NODE_COUNT (NODE_COUNT),
    .HEAD_NODE  (HEAD_NODE),
    .AW         (AW)
  ) u_walker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_node_index (in_node_index),
    .in_link_zero  (in_link_zero),
    .in_link_one   (in_link_one),
    .in_code_byte  (in_code_byte),
    .tbl_wr_en     (tbl_wr_en),
    .tbl_wr_addr   (tbl_wr_addr),
    .tbl_wr_data   (tbl_wr_data),
    .tbl_rd_addr   (tbl_rd_addr),
    .tbl_rd_data   (tbl_rd_data),
    .out_free      (out_free),
    .push          (push),
    .push_res      (push_res)
  );

  // Output register: free when empty or being taken this cycle
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (push) begin
      out_res_r <= push_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_res_r.symbol;
  assign out_last_of_item = out_res_r.last;
  assign out_chunk_end    = out_res_r.chunk_end;
  assign out_bad_link     = out_res_r.bad_link;

  `HUFD_ASSERT(a_bad_result_clean, clk, rst_n, (out_valid_r && out_res_r.bad_link) |-> (out_res_r.symbol == '0 && !out_res_r.chunk_end && out_res_r.last), "bad-link result carries symbol data")

endmodule
